// ----- sv/cpp_pkg.sv -----
package cpp_pkg;

    localparam int TableDepth = 256;
    localparam int CountBits  = 24;
    localparam int ColorBits  = 24;
    localparam int RankBits   = 8;

    localparam logic [1:0] MODE_COUNT = 2'd0;
    localparam logic [1:0] MODE_SORT  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [ColorBits-1:0] WHITE     = 24'hFFFFFF;
    localparam logic [RankBits-1:0]  LAST_RANK = 8'd255;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CSCAN  = 9'b000000010,
        S_CCHK   = 9'b000000100,
        S_SINIT  = 9'b000001000,
        S_SSCAN  = 9'b000010000,
        S_SWAPA  = 9'b000100000,
        S_SWAPB  = 9'b001000000,
        S_RWAIT  = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    // command from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic rd_i;       // read address i
        logic rd_j;       // read address j
        logic rd_best;    // read address best
        logic set_i;      // j <= i+1, best <= i, best_count from data
        logic inc_i;
        logic inc_j;
        logic cmp_j;      // compare count at j with best
        logic hit_upd;    // write incremented count at j
        logic append;     // write new entry at entries_used
        logic wr_i_best;  // write best data at i
        logic wr_best_i;  // write held i data at best
        logic clear;
        logic capture_rd; // latch read result
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic j_end;       // j >= entries_used
        logic i_end;       // i + 1 >= entries_used
        logic hit;         // read colour equals pixel
        logic best_is_i;
    } stat_t;

endpackage

// ----- sv/cpp_datapath.sv -----
module cpp_datapath #(
    parameter int TABLE_DEPTH = cpp_pkg::TableDepth,
    parameter int COUNT_BITS  = cpp_pkg::CountBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpp_pkg::cmd_t                 cmd,
    output cpp_pkg::stat_t                stat,
    input  logic [1:0]                    mode,
    input  logic [cpp_pkg::ColorBits-1:0] pixel_color,
    input  logic [cpp_pkg::RankBits-1:0]  rank,
    input  logic                          cfg_valid,
    input  logic [7:0]                    cfg_data,
    output logic [cpp_pkg::ColorBits-1:0] res_color,
    output logic [cpp_pkg::ColorBits-1:0] res_count,
    output logic [8:0]                    res_distinct,
    output logic                          res_dropped
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam int XW = NW + cpp_pkg::RankBits;
    localparam int CW = cpp_pkg::ColorBits;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [CW-1:0]         color_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];

    logic [1:0]            mode_reg;
    logic [CW-1:0]         pix_reg;
    logic [cpp_pkg::RankBits-1:0] rank_reg;
    logic [7:0]            pal_reg;
    logic [NW-1:0]         used_reg, used_next;
    logic [NW-1:0]         i_reg, j_reg, best_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [CW-1:0]         rd_color_reg, hold_color_reg;
    logic [COUNT_BITS-1:0] rd_count_reg, hold_count_reg;
    logic [AW-1:0]         raddr, waddr;
    logic                  we;
    logic [CW-1:0]         wcolor;
    logic [COUNT_BITS-1:0] wcount;
    logic [NW-1:0]         i_plus1;
    logic                  drop_now, rd_ok;

    assign i_plus1 = i_reg + NW'(1);

    always_comb
    begin
        raddr = i_reg[AW-1:0];
        if (cmd.rd_j)
        begin
            raddr = j_reg[AW-1:0];
        end
        else if (cmd.rd_best)
        begin
            raddr = best_reg[AW-1:0];
        end
        else if (cmd.load)
        begin
            raddr = AW'(rank);
        end
    end

    always_comb
    begin
        we     = 1'b0;
        waddr  = j_reg[AW-1:0];
        wcolor = rd_color_reg;
        wcount = rd_count_reg;
        if (cmd.hit_upd)
        begin
            we     = 1'b1;
            wcount = (rd_count_reg == CMAX) ? rd_count_reg : rd_count_reg + COUNT_BITS'(1);
        end
        else if (cmd.append)
        begin
            we     = ~drop_now;
            waddr  = used_reg[AW-1:0];
            wcolor = pix_reg;
            wcount = COUNT_BITS'(1);
        end
        else if (cmd.wr_i_best)
        begin
            we    = 1'b1;
            waddr = i_reg[AW-1:0];
        end
        else if (cmd.wr_best_i)
        begin
            we     = 1'b1;
            waddr  = best_reg[AW-1:0];
            wcolor = hold_color_reg;
            wcount = hold_count_reg;
        end
    end

    assign drop_now = (used_reg == NW'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            color_mem[waddr] <= wcolor;
            count_mem[waddr] <= wcount;
        end
        rd_color_reg <= color_mem[raddr];
        rd_count_reg <= count_mem[raddr];
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.clear)
        begin
            used_next = '0;
        end
        else if (cmd.append && !drop_now)
        begin
            used_next = used_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            pal_reg  <= 8'd255;
        end
        else
        begin
            used_reg <= used_next;
            if (cfg_valid)
            begin
                pal_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            pix_reg  <= pixel_color;
            rank_reg <= rank;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        if (cmd.set_i)
        begin
            j_reg        <= i_plus1;
            best_reg     <= i_reg;
            best_cnt_reg <= rd_count_reg;
        end
        if (cmd.inc_j)
        begin
            j_reg <= j_reg + NW'(1);
        end
        if (cmd.cmp_j && rd_count_reg > best_cnt_reg)
        begin
            best_reg     <= j_reg - NW'(1);
            best_cnt_reg <= rd_count_reg;
        end
        if (cmd.inc_i)
        begin
            i_reg <= i_plus1;
        end
        if (cmd.capture_rd)
        begin
            hold_color_reg <= rd_color_reg;
            hold_count_reg <= rd_count_reg;
        end
        if (cmd.res_load)
        begin
            res_distinct <= 9'(used_next);
            res_color    <= (mode_reg == cpp_pkg::MODE_READ)
                            ? (rd_ok ? rd_color_reg : cpp_pkg::WHITE) : '0;
            res_count    <= (mode_reg == cpp_pkg::MODE_READ && rd_ok)
                            ? CW'(rd_count_reg) : '0;
            res_dropped  <= (mode_reg == cpp_pkg::MODE_COUNT) & cmd.append & drop_now;
        end
    end

    assign rd_ok = (rank_reg != cpp_pkg::LAST_RANK) && (rank_reg < pal_reg)
                   && (XW'(rank_reg) < XW'(used_reg));

    assign stat.j_end     = (j_reg >= used_reg);
    assign stat.i_end     = (i_plus1 >= used_reg);
    assign stat.hit       = (rd_color_reg == pix_reg);
    assign stat.best_is_i = (best_reg == i_reg);

endmodule

// ----- sv/cpp_ctrl.sv -----
module cpp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [1:0]     mode,
    input  logic           out_free,
    output logic           busy,
    output logic           res_set,
    output cpp_pkg::cmd_t  cmd,
    input  cpp_pkg::stat_t stat
);
    cpp_pkg::state_t state_reg, state_next;
    logic cnt_first_reg, cnt_first_next;

    // counting: read j in CSCAN, data checked in CCHK, which increments j on a miss
    // sort: SINIT reads i, then SSCAN streams j reads, each compared in the cycle after its read
    always_comb
    begin
        state_next     = state_reg;
        cnt_first_next = cnt_first_reg;
        cmd            = '0;
        res_set        = 1'b0;
        unique case (state_reg)
            cpp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    unique case (mode)
                        cpp_pkg::MODE_COUNT: state_next = cpp_pkg::S_CSCAN;
                        cpp_pkg::MODE_SORT:  state_next = cpp_pkg::S_SINIT;
                        cpp_pkg::MODE_READ:  state_next = cpp_pkg::S_RWAIT;
                        default:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = cpp_pkg::S_RWAIT;
                        end
                    endcase
                end
            end
            cpp_pkg::S_CSCAN:
            begin
                if (stat.j_end)
                begin
                    cmd.append   = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = cpp_pkg::S_OUT;
                end
                else
                begin
                    cmd.rd_j   = 1'b1;
                    state_next = cpp_pkg::S_CCHK;
                end
            end
            cpp_pkg::S_CCHK:
            begin
                if (stat.hit)
                begin
                    cmd.hit_upd  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = cpp_pkg::S_OUT;
                end
                else
                begin
                    cmd.inc_j  = 1'b1;
                    state_next = cpp_pkg::S_CSCAN;
                end
            end
            cpp_pkg::S_SINIT:
            begin
                if (stat.i_end)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = cpp_pkg::S_OUT;
                end
                else if (!cnt_first_reg)
                begin
                    cmd.rd_i       = 1'b1;
                    cnt_first_next = 1'b1;
                end
                else
                begin
                    cmd.set_i      = 1'b1;
                    cnt_first_next = 1'b0;
                    state_next     = cpp_pkg::S_SSCAN;
                end
            end
            cpp_pkg::S_SSCAN:
            begin
                cmd.cmp_j = cnt_first_reg;
                if (stat.j_end)
                begin
                    cnt_first_next = 1'b0;
                    if (cnt_first_reg)
                    begin
                        state_next = cpp_pkg::S_SSCAN;
                    end
                    else
                    begin
                        state_next = cpp_pkg::S_SWAPA;
                    end
                end
                else
                begin
                    cmd.rd_j       = 1'b1;
                    cmd.inc_j      = 1'b1;
                    cnt_first_next = 1'b1;
                end
            end
            cpp_pkg::S_SWAPA:
            begin
                if (stat.best_is_i)
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = cpp_pkg::S_SINIT;
                end
                else if (!cnt_first_reg)
                begin
                    cmd.rd_i       = 1'b1;
                    cnt_first_next = 1'b1;
                end
                else
                begin
                    cmd.capture_rd = 1'b1;
                    cmd.rd_best    = 1'b1;
                    cnt_first_next = 1'b0;
                    state_next     = cpp_pkg::S_SWAPB;
                end
            end
            cpp_pkg::S_SWAPB:
            begin
                if (!cnt_first_reg)
                begin
                    cmd.wr_i_best  = 1'b1;
                    cnt_first_next = 1'b1;
                end
                else
                begin
                    cmd.wr_best_i  = 1'b1;
                    cmd.inc_i      = 1'b1;
                    cnt_first_next = 1'b0;
                    state_next     = cpp_pkg::S_SINIT;
                end
            end
            cpp_pkg::S_RWAIT:
            begin
                cmd.res_load = 1'b1;
                state_next   = cpp_pkg::S_OUT;
            end
            cpp_pkg::S_OUT:
            begin
                if (!out_free)
                begin
                    state_next = cpp_pkg::S_OUT;
                end
                else
                begin
                    res_set        = 1'b1;
                    cnt_first_next = 1'b0;
                    state_next     = cpp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cpp_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != cpp_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpp_pkg::S_IDLE;
            cnt_first_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_first_reg <= cnt_first_next;
        end
    end

endmodule

// ----- sv/color_popularity_palette.sv -----
// Popularity palette builder. Each transfer on s_axis carries a mode: count
// a 24-bit colour (linear search over the table entries in use), sort by
// descending count (selection sort), read a palette rank or clear. Exactly
// one result per item leaves on m_axis; the next item is taken once the
// result has been registered for output. The user is to write palette_used
// through cfg_valid/cfg_ready only while idle; the block itself does not
// enforce it.
module color_popularity_palette #(
    parameter int TABLE_DEPTH = cpp_pkg::TableDepth,
    parameter int COUNT_BITS  = cpp_pkg::CountBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // mode, pixel_color, rank, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_color, out_count, distinct_colors, dropped, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    cpp_pkg::cmd_t  cmd;
    cpp_pkg::stat_t stat;
    logic           busy, res_set, in_fire;
    logic           ovalid_reg;
    logic [23:0]    rc, rn;
    logic [8:0]     rd;
    logic           rdrop;

    assign s_axis_tready = ~busy;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;

    cpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .mode     (s_axis_tdata[1:0]),
        .out_free (~ovalid_reg | m_axis_tready),
        .busy     (busy),
        .res_set  (res_set),
        .cmd      (cmd),
        .stat     (stat)
    );

    cpp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (s_axis_tdata[1:0]),
        .pixel_color  (s_axis_tdata[25:2]),
        .rank         (s_axis_tdata[33:26]),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .res_color    (rc),
        .res_count    (rn),
        .res_distinct (rd),
        .res_dropped  (rdrop)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (res_set)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_set)
        begin
            m_axis_tdata <= {6'd0, rdrop, rd, rn, rc};
        end
    end

    assign m_axis_tvalid = ovalid_reg;

endmodule
